// File: rtl/tct_pkg.sv
// Package for the tunnel connection table: field widths, codes and FSM type.
// No dependencies; used by the interfaces and the top-level module of the block.
package tct_pkg;

   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = IP_W + 2 * PORT_W;

   // request kinds
   localparam logic KIND_LEARN  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FIXED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EXISTS  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// File: rtl/tct_if.sv
// Valid/ready channel interfaces of the tunnel connection table.
// Depends on tct_pkg for field widths.
interface tct_req_if import tct_pkg::*;;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [IP_W-1:0]   ip_addr;
   logic [PORT_W-1:0] udp_port;
   logic [PORT_W-1:0] tcp_port;

   modport source (output valid, output kind, output ip_addr, output udp_port,
                   output tcp_port, input ready);
   modport sink   (input valid, input kind, input ip_addr, input udp_port,
                   input tcp_port, output ready);
endinterface

interface tct_rsp_if import tct_pkg::*;;
   logic                valid;
   logic                ready;
   logic [PORT_W-1:0]   port_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output port_out, output status, input ready);
   modport sink   (input valid, input port_out, input status, output ready);
endinterface

interface tct_csr_if import tct_pkg::*;;
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tunnel_connection_table.sv
// Top level of the tunnel connection table: control FSM, fill count and result register.
// Depends on tct_pkg, the channel interfaces in tct_if and the generic tct_ram.

// A request is a learn or a lookup. Entries live in one RAM in order of arrival;
// outside client mode (fixed endpoint port nonzero) each request scans it through
// the single read port, one entry per cycle, a learn from the oldest entry up and a
// lookup from the newest down, stopping at the first match; in client mode it is
// answered without a scan. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken. A learn of a new
// triple into a full table is refused with status 5. The configuration register is
// always ready.
module tunnel_connection_table import tct_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   tct_req_if.sink    req,
   tct_rsp_if.source  rsp,
   tct_csr_if.sink    csr
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   logic                cmp_ff, cmp_in;
   logic [PORT_W-1:0]   fixed_ff, fixed_in;
   logic                kind_ff, kind_in;
   logic [IP_W-1:0]     ip_ff, ip_in;
   logic [PORT_W-1:0]   udp_ff, udp_in;
   logic [PORT_W-1:0]   tcp_ff, tcp_in;
   logic [PORT_W-1:0]   res_port_ff, res_port_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                rd_en;
   logic                wr_en;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ENTRY_W-1:0]  entry_want;
   logic [FILL_W-1:0]   fill_dec;
   logic                learn_match;
   logic                lookup_match;
   logic                match;
   logic [PORT_W-1:0]   hit_udp;

   // entry store
   tct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(fill_ff)),
      .wr_data (entry_want),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // compare the entry read last cycle against the held request
   assign entry_want   = {ip_ff, udp_ff, tcp_ff};
   assign hit_udp      = rd_data[2*PORT_W-1:PORT_W];
   assign learn_match  = (rd_data == entry_want);
   assign lookup_match = (rd_data[ENTRY_W-1:2*PORT_W] == ip_ff) &&
                         (rd_data[PORT_W-1:0] == tcp_ff);
   assign match        = cmp_ff && ((kind_ff == KIND_LEARN) ? learn_match : lookup_match);
   assign fill_dec     = fill_ff - FILL_W'(1);

   // configuration register write
   assign csr.ready = 1'b1;
   always_comb begin
      fixed_in = csr.valid ? csr.data : fixed_ff;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      addr_in       = addr_ff;
      cmp_in        = 1'b0;
      kind_in       = kind_ff;
      ip_in         = ip_ff;
      udp_in        = udp_ff;
      tcp_in        = tcp_ff;
      res_port_in   = res_port_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_port_in   = rsp_port_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      req.ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               kind_in = req.kind;
               ip_in   = req.ip_addr;
               udp_in  = req.udp_port;
               tcp_in  = req.tcp_port;
               if (fixed_ff != '0) begin
                  // client mode: answer at once
                  if (req.kind == KIND_LOOKUP) begin
                     res_port_in   = fixed_ff;
                     res_status_in = STAT_FIXED;
                  end else begin
                     res_port_in   = '0;
                     res_status_in = STAT_REFUSED;
                  end
                  state_in = ST_DONE;
               end else begin
                  // start the scan: learn upward, lookup from the newest entry down
                  left_in  = fill_ff;
                  addr_in  = (req.kind == KIND_LEARN) ? '0 : IDX_W'(fill_dec);
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue the next read while comparing the previous one
            rd_en = (left_ff != '0);
            cmp_in = rd_en;
            if (rd_en) begin
               left_in = left_ff - FILL_W'(1);
               addr_in = (kind_ff == KIND_LEARN) ? addr_ff + IDX_W'(1) : addr_ff - IDX_W'(1);
            end
            if (match) begin
               cmp_in = 1'b0;
               if (kind_ff == KIND_LEARN) begin
                  res_port_in   = '0;
                  res_status_in = STAT_EXISTS;
               end else if (hit_udp == '0) begin
                  // newest match holds no usable port
                  res_port_in   = '0;
                  res_status_in = STAT_MISS;
               end else begin
                  res_port_in   = hit_udp;
                  res_status_in = STAT_HIT;
               end
               state_in = ST_DONE;
            end else if (left_ff == '0) begin
               res_port_in = '0;
               if (kind_ff == KIND_LOOKUP) begin
                  res_status_in = STAT_MISS;
               end else if (fill_ff == FILL_W'(TABLE_DEPTH)) begin
                  res_status_in = STAT_REFUSED;
               end else begin
                  // append the new triple
                  wr_en         = 1'b1;
                  fill_in       = fill_ff + FILL_W'(1);
                  res_status_in = STAT_ADDED;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_port_in   = res_port_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cmp_ff       <= 1'b0;
         fixed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_ff       <= cmp_in;
         fixed_ff     <= fixed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      addr_ff       <= addr_in;
      kind_ff       <= kind_in;
      ip_ff         <= ip_in;
      udp_ff        <= udp_in;
      tcp_ff        <= tcp_in;
      res_port_ff   <= res_port_in;
      res_status_ff <= res_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.port_out = rsp_port_ff;
   assign rsp.status   = rsp_status_ff;

endmodule
